@@ rtl/sai_pkg.sv @@
// shared types, codes and sizes for the sorted array unit
package sai_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_DEL_RD,
    ST_DEL_CHK,
    ST_SR_RD,
    ST_SR_CMP,
    ST_RD_RD,
    ST_RD_DATA,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]         raddr;
  } ram_req_t;

  typedef struct packed {
    logic eq;
    logic lt;
    logic gt;
  } cmp_res_t;

endpackage

@@ rtl/sai_if.sv @@
// request and result channel interfaces
interface sai_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       command;
  logic signed [sai_pkg::DATA_W-1:0] key_value;
  logic [sai_pkg::IDX_W-1:0]        read_index;

  modport source (output valid, command, key_value, read_index, input ready);
  modport sink   (input valid, command, key_value, read_index, output ready);
endinterface

interface sai_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [sai_pkg::IDX_W-1:0]        found_index;
  logic signed [sai_pkg::DATA_W-1:0] entry_value;
  logic [sai_pkg::CNT_W-1:0]        count_after;

  modport source (output valid, status, found_index, entry_value, count_after,
                  input ready);
  modport sink   (input valid, status, found_index, entry_value, count_after,
                  output ready);
endinterface

@@ rtl/sai_cmp.sv @@
// shared signed comparator used by the insert, delete and search steps
module sai_cmp (
  input  logic signed [sai_pkg::DATA_W-1:0] a,
  input  logic signed [sai_pkg::DATA_W-1:0] b,
  output sai_pkg::cmp_res_t                 res
);

  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
    res.gt = (a > b);
  end

endmodule

@@ rtl/sai_ram.sv @@
// entry store: one write port, one registered read port
module sai_ram (
  input  logic                              clk,
  input  sai_pkg::ram_req_t                 req,
  output logic signed [sai_pkg::DATA_W-1:0] rd_data
);

  logic signed [sai_pkg::DATA_W-1:0] mem [sai_pkg::CAPACITY];
  logic signed [sai_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/sai_seq.sv @@
// command sequencer: walks the store one entry per step
module sai_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  sai_in_if.sink                            in_chan,
  sai_out_if.source                         out_chan,
  output sai_pkg::ram_req_t                 ram_req,
  input  logic signed [sai_pkg::DATA_W-1:0] rd_data,
  output logic signed [sai_pkg::DATA_W-1:0] key,
  input  sai_pkg::cmp_res_t                 cmp_res
);

  localparam int IW = sai_pkg::IDX_W;
  localparam int CW = sai_pkg::CNT_W;
  localparam int DW = sai_pkg::DATA_W;
  localparam logic [CW-1:0] CAP = CW'(sai_pkg::CAPACITY);

  sai_pkg::state_t state_r, state_nxt;
  sai_pkg::cmd_t   cmd_r, cmd_nxt;
  logic signed [DW-1:0] key_r, key_nxt;
  logic [IW-1:0]   ridx_r, ridx_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  // a: insert position / delete read index / search low bound
  // b: delete write index / search high bound
  logic [CW-1:0]   a_r, a_nxt;
  logic [CW-1:0]   b_r, b_nxt;
  sai_pkg::status_t st_r, st_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic signed [DW-1:0] val_r, val_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [IW-1:0]   out_idx_r, out_idx_nxt;
  logic signed [DW-1:0] out_val_r, out_val_nxt;
  logic [CW-1:0]   out_cnt_r, out_cnt_nxt;

  logic [CW:0]     mid_sum;
  logic [CW-1:0]   mid;

  // floor midpoint of the window [a, b)
  assign mid_sum = {1'b0, a_r} + {1'b0, b_r} - {{CW{1'b0}}, 1'b1};
  assign mid     = mid_sum[CW:1];

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    ridx_nxt       = ridx_r;
    cnt_nxt        = cnt_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    st_nxt         = st_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_val_nxt    = out_val_r;
    out_cnt_nxt    = out_cnt_r;
    ram_req.we     = 1'b0;
    ram_req.waddr  = a_r[IW-1:0];
    ram_req.wdata  = key_r;
    ram_req.raddr  = a_r[IW-1:0];
    in_chan.ready  = (state_r == sai_pkg::ST_IDLE);

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sai_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          cmd_nxt  = sai_pkg::cmd_t'(in_chan.command);
          key_nxt  = in_chan.key_value;
          ridx_nxt = in_chan.read_index;
          st_nxt   = sai_pkg::STAT_OK;
          idx_nxt  = '0;
          val_nxt  = '0;
          case (sai_pkg::cmd_t'(in_chan.command))
            sai_pkg::CMD_INSERT: begin
              a_nxt = cnt_r;
              if (cnt_r >= CAP) begin
                st_nxt    = sai_pkg::STAT_FULL;
                state_nxt = sai_pkg::ST_FIN;
              end else begin
                state_nxt = sai_pkg::ST_INS_RD;
              end
            end
            sai_pkg::CMD_DELETE: begin
              a_nxt     = '0;
              b_nxt     = '0;
              state_nxt = sai_pkg::ST_DEL_RD;
            end
            sai_pkg::CMD_SEARCH: begin
              a_nxt     = '0;
              b_nxt     = cnt_r;
              state_nxt = sai_pkg::ST_SR_RD;
            end
            sai_pkg::CMD_READ: begin
              state_nxt = sai_pkg::ST_RD_RD;
            end
            default: begin
              state_nxt = sai_pkg::ST_FIN;
            end
          endcase
        end
      end

      sai_pkg::ST_INS_RD: begin
        if (a_r == '0) begin
          ram_req.we = 1'b1;
          idx_nxt    = '0;
          cnt_nxt    = cnt_r + 1'b1;
          state_nxt  = sai_pkg::ST_FIN;
        end else begin
          ram_req.raddr = IW'(a_r - 1'b1);
          state_nxt     = sai_pkg::ST_INS_CMP;
        end
      end

      sai_pkg::ST_INS_CMP: begin
        ram_req.we = 1'b1;
        if (cmp_res.gt) begin
          // larger entry moves up one place
          ram_req.wdata = rd_data;
          a_nxt         = a_r - 1'b1;
          state_nxt     = sai_pkg::ST_INS_RD;
        end else begin
          idx_nxt   = a_r[IW-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = sai_pkg::ST_FIN;
        end
      end

      sai_pkg::ST_DEL_RD: begin
        if (a_r == cnt_r) begin
          st_nxt    = (b_r < cnt_r) ? sai_pkg::STAT_OK : sai_pkg::STAT_NOT_FOUND;
          cnt_nxt   = b_r;
          state_nxt = sai_pkg::ST_FIN;
        end else begin
          state_nxt = sai_pkg::ST_DEL_CHK;
        end
      end

      sai_pkg::ST_DEL_CHK: begin
        if (!cmp_res.eq) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = b_r[IW-1:0];
          ram_req.wdata = rd_data;
          b_nxt         = b_r + 1'b1;
        end
        a_nxt     = a_r + 1'b1;
        state_nxt = sai_pkg::ST_DEL_RD;
      end

      sai_pkg::ST_SR_RD: begin
        ram_req.raddr = mid[IW-1:0];
        if (a_r < b_r) begin
          state_nxt = sai_pkg::ST_SR_CMP;
        end else begin
          st_nxt    = sai_pkg::STAT_NOT_FOUND;
          state_nxt = sai_pkg::ST_FIN;
        end
      end

      sai_pkg::ST_SR_CMP: begin
        if (cmp_res.eq) begin
          idx_nxt   = mid[IW-1:0];
          state_nxt = sai_pkg::ST_FIN;
        end else begin
          if (cmp_res.lt) begin
            a_nxt = mid + 1'b1;
          end else begin
            b_nxt = mid;
          end
          state_nxt = sai_pkg::ST_SR_RD;
        end
      end

      sai_pkg::ST_RD_RD: begin
        ram_req.raddr = ridx_r;
        idx_nxt       = ridx_r;
        if ({1'b0, ridx_r} < cnt_r) begin
          state_nxt = sai_pkg::ST_RD_DATA;
        end else begin
          st_nxt    = sai_pkg::STAT_BAD_INDEX;
          state_nxt = sai_pkg::ST_FIN;
        end
      end

      sai_pkg::ST_RD_DATA: begin
        val_nxt   = rd_data;
        state_nxt = sai_pkg::ST_FIN;
      end

      sai_pkg::ST_FIN: begin
        // hand over once the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_idx_nxt    = idx_r;
          out_val_nxt    = val_r;
          out_cnt_nxt    = cnt_r;
          state_nxt      = sai_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sai_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sai_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    ridx_r       <= ridx_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    st_r         <= st_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_val_r    <= out_val_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign key                  = key_r;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.found_index = out_idx_r;
  assign out_chan.entry_value = out_val_r;
  assign out_chan.count_after = out_cnt_r;

endmodule

@@ rtl/sorted_array_insert_delete_search_unit.sv @@
// top level of the sorted array unit with insert, delete, search and read
//
//  channel    dir  handshake     payload
//  in_chan    in   valid/ready   command, key_value, read_index
//  out_chan   out  valid/ready   status, found_index, entry_value, count_after
//
// each command steps through the store entry by entry, a read step then a compare
// step per entry visited, set by the single registered read port shared with
// the comparator: insert visits the k entries it moves and at most one more,
// delete all n, search halves its window; bad reads and full inserts skip the store
// rst_n is synchronous active low; it clears the count, the store is not cleared
// a new request is taken once the previous result sits in the output register;
// a stalled result holds the sequencer in its final state until it is taken
module sorted_array_insert_delete_search_unit (
  input  logic      clk,
  input  logic      rst_n,
  sai_in_if.sink    in_chan,
  sai_out_if.source out_chan
);

  sai_pkg::ram_req_t                 ram_req;
  sai_pkg::cmp_res_t                 cmp_res;
  logic signed [sai_pkg::DATA_W-1:0] rd_data;
  logic signed [sai_pkg::DATA_W-1:0] key;

  sai_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .ram_req  (ram_req),
    .rd_data  (rd_data),
    .key      (key),
    .cmp_res  (cmp_res)
  );

  sai_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  sai_cmp u_cmp (
    .a   (rd_data),
    .b   (key),
    .res (cmp_res)
  );

`ifndef SYNTHESIS
  localparam logic [sai_pkg::CNT_W-1:0] CAP_CNT = sai_pkg::CNT_W'(sai_pkg::CAPACITY);

  // a taken request keeps the unit busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("unit ready again right after a request");

  // the store is only written while a request is in progress
  a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> !in_chan.ready)
    else $error("store written while idle");

  // full is reported only with the array at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status == sai_pkg::STAT_FULL |->
      out_chan.count_after == CAP_CNT && out_chan.found_index == '0)
    else $error("full reported below capacity");

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.count_after <= CAP_CNT)
    else $error("count beyond capacity");
`endif

endmodule
